// ===== sv/uyvy_pkg.sv =====
// ----------------------------------------------------------------------------
// uyvy_pkg
// Shared widths, coefficients, types and helpers of the UYVY to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package uyvy_pkg;

  localparam int unsigned ByteW = 8;
  // Fraction bits of the chroma coefficients (scale 1024)
  localparam int unsigned FracW = 10;
  // Signed product width: |1814 * -128| = 232192 < 2^18
  localparam int unsigned ProdW = 19;
  // Signed chroma term width after the floor shift: -227..224
  localparam int unsigned TermW = ProdW - FracW;
  // Signed width of luma plus or minus a term: -227..479
  localparam int unsigned SumW = ByteW + 2;

  localparam logic signed [ProdW-1:0] CoefRedV   = ProdW'(1436);
  localparam logic signed [ProdW-1:0] CoefGreenU = ProdW'(352);
  localparam logic signed [ProdW-1:0] CoefGreenV = ProdW'(731);
  localparam logic signed [ProdW-1:0] CoefBlueU  = ProdW'(1814);

  localparam logic [ByteW-1:0] ChanMax = 8'd255;
  localparam logic [ByteW-1:0] ChanMin = 8'd0;

  // Chroma terms shared by both pixels of a macropixel
  typedef struct packed {
    logic signed [TermW-1:0] red;
    logic signed [TermW-1:0] green;
    logic signed [TermW-1:0] blue;
  } chroma_terms_t;

  // Clamp a signed sum to 0..255
  function automatic logic [ByteW-1:0] sat_byte(input logic signed [SumW-1:0] x);
    logic [ByteW-1:0] res;
    if (x[SumW-1]) begin
      res = ChanMin;
    end else if (x[SumW-2]) begin
      res = ChanMax;
    end else begin
      res = x[ByteW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/uyvy_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// uyvy_to_rgb_converter_core
// UYVY 4:2:2 macropixel to two RGB888 pixels, one macropixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Each request carries one macropixel (U, Y0, V, Y1 and an end-of-frame mark)
// and yields exactly one result holding the two RGB888 pixels that share its
// chroma. The block takes one request per clock while the output is not
// stalled. The request is first captured in an input register, the chroma
// terms, luma sums and clamping are then worked out in a single pass of
// logic, and the result lands in an output register. The result is shown
// once its item moves on from the input register into the output register.
// Both registers move independently, so a new request is taken while a
// finished result waits on a stalled output; in_ready_o drops only when both
// registers hold an item and the output is stalled.
// Arithmetic, with u = U - 128 and v = V - 128:
//   R = Y + floor(1436 v / 1024), G = Y - floor((352 u + 731 v) / 1024),
//   B = Y + floor(1814 u / 1024), each channel clamped to 0..255.
// The end-of-frame mark travels with the item unchanged. No state is kept
// between items, so reset only empties the two registers.
// ----------------------------------------------------------------------------
`default_nettype none

module uyvy_to_rgb_converter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request side
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [uyvy_pkg::ByteW-1:0] chroma_u_i,
  input  logic [uyvy_pkg::ByteW-1:0] luma_first_i,
  input  logic [uyvy_pkg::ByteW-1:0] chroma_v_i,
  input  logic [uyvy_pkg::ByteW-1:0] luma_second_i,
  input  logic                       frame_end_in_i,
  // result side
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [uyvy_pkg::ByteW-1:0] red_first_o,
  output logic [uyvy_pkg::ByteW-1:0] green_first_o,
  output logic [uyvy_pkg::ByteW-1:0] blue_first_o,
  output logic [uyvy_pkg::ByteW-1:0] red_second_o,
  output logic [uyvy_pkg::ByteW-1:0] green_second_o,
  output logic [uyvy_pkg::ByteW-1:0] blue_second_o,
  output logic                       frame_end_out_o
);

  // --- input register -------------------------------------------------------
  logic                       in_vld_q;
  logic [uyvy_pkg::ByteW-1:0] chroma_u_q;
  logic [uyvy_pkg::ByteW-1:0] luma_first_q;
  logic [uyvy_pkg::ByteW-1:0] chroma_v_q;
  logic [uyvy_pkg::ByteW-1:0] luma_second_q;
  logic                       frame_end_q;

  // --- output register ------------------------------------------------------
  logic                       out_vld_q;
  logic [uyvy_pkg::ByteW-1:0] red_first_q;
  logic [uyvy_pkg::ByteW-1:0] green_first_q;
  logic [uyvy_pkg::ByteW-1:0] blue_first_q;
  logic [uyvy_pkg::ByteW-1:0] red_second_q;
  logic [uyvy_pkg::ByteW-1:0] green_second_q;
  logic [uyvy_pkg::ByteW-1:0] blue_second_q;
  logic                       frame_end_out_q;

  // --- conversion logic between the registers ------------------------------
  uyvy_pkg::chroma_terms_t    terms;
  logic [uyvy_pkg::ByteW-1:0] red_first_d;
  logic [uyvy_pkg::ByteW-1:0] green_first_d;
  logic [uyvy_pkg::ByteW-1:0] blue_first_d;
  logic [uyvy_pkg::ByteW-1:0] red_second_d;
  logic [uyvy_pkg::ByteW-1:0] green_second_d;
  logic [uyvy_pkg::ByteW-1:0] blue_second_d;

  // flow control
  logic out_free;   // output register can take an item this cycle
  logic advance;    // input register hands its item on
  logic in_fire;    // request accepted

  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Chroma terms are computed once and shared by both pixels
  uyvy_chroma u_chroma (
    .chroma_u_i (chroma_u_q),
    .chroma_v_i (chroma_v_q),
    .terms_o    (terms)
  );

  uyvy_pixel u_pixel_first (
    .luma_i  (luma_first_q),
    .terms_i (terms),
    .red_o   (red_first_d),
    .green_o (green_first_d),
    .blue_o  (blue_first_d)
  );

  uyvy_pixel u_pixel_second (
    .luma_i  (luma_second_q),
    .terms_i (terms),
    .red_o   (red_second_d),
    .green_o (green_second_d),
    .blue_o  (blue_second_d)
  );

  // Valid flags: cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  // Payload registers: loaded on a transfer, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chroma_u_q    <= chroma_u_i;
      luma_first_q  <= luma_first_i;
      chroma_v_q    <= chroma_v_i;
      luma_second_q <= luma_second_i;
      frame_end_q   <= frame_end_in_i;
    end
    if (advance) begin
      red_first_q     <= red_first_d;
      green_first_q   <= green_first_d;
      blue_first_q    <= blue_first_d;
      red_second_q    <= red_second_d;
      green_second_q  <= green_second_d;
      blue_second_q   <= blue_second_d;
      frame_end_out_q <= frame_end_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign red_first_o     = red_first_q;
  assign green_first_o   = green_first_q;
  assign blue_first_o    = blue_first_q;
  assign red_second_o    = red_second_q;
  assign green_second_o  = green_second_q;
  assign blue_second_o   = blue_second_q;
  assign frame_end_out_o = frame_end_out_q;

  // --- assertions -----------------------------------------------------------

  // Back-pressure only when both registers are occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q))
    else $error("in_ready_o low while a register is free");

  // An accepted request is held in the input register next cycle
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_vld_q)
    else $error("accepted request lost from the input register");

  // An item handed on shows up as a result
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("item handed on but no result shown");

  // End-of-frame mark travels with its item
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (frame_end_out_o == $past(frame_end_q)))
    else $error("end-of-frame mark not carried with its item");

  // Equal luma samples must give identical pixels
  a_equal_luma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (luma_first_q == luma_second_q)) |=>
      (red_first_o == red_second_o) && (green_first_o == green_second_o) &&
      (blue_first_o == blue_second_o))
    else $error("pixels differ despite equal luma");

endmodule

`default_nettype wire

// ===== sv/uyvy_chroma.sv =====
// ----------------------------------------------------------------------------
// uyvy_chroma
// Removes the chroma bias and forms the floored red, green and blue terms.
// ----------------------------------------------------------------------------
`default_nettype none

module uyvy_chroma (
  input  logic [uyvy_pkg::ByteW-1:0] chroma_u_i,
  input  logic [uyvy_pkg::ByteW-1:0] chroma_v_i,
  output uyvy_pkg::chroma_terms_t    terms_o
);

  logic signed [uyvy_pkg::ByteW-1:0] u_s;
  logic signed [uyvy_pkg::ByteW-1:0] v_s;
  logic signed [uyvy_pkg::ProdW-1:0] red_p;
  logic signed [uyvy_pkg::ProdW-1:0] green_p;
  logic signed [uyvy_pkg::ProdW-1:0] blue_p;

  // Offset binary to two's complement: byte - 128
  assign u_s = {~chroma_u_i[uyvy_pkg::ByteW-1], chroma_u_i[uyvy_pkg::ByteW-2:0]};
  assign v_s = {~chroma_v_i[uyvy_pkg::ByteW-1], chroma_v_i[uyvy_pkg::ByteW-2:0]};

  assign red_p   = uyvy_pkg::ProdW'(v_s) * uyvy_pkg::CoefRedV;
  assign green_p = uyvy_pkg::ProdW'(u_s) * uyvy_pkg::CoefGreenU
                 + uyvy_pkg::ProdW'(v_s) * uyvy_pkg::CoefGreenV;
  assign blue_p  = uyvy_pkg::ProdW'(u_s) * uyvy_pkg::CoefBlueU;

  // Dropping the low fraction bits of a two's complement value is a floor
  assign terms_o.red   = red_p[uyvy_pkg::ProdW-1:uyvy_pkg::FracW];
  assign terms_o.green = green_p[uyvy_pkg::ProdW-1:uyvy_pkg::FracW];
  assign terms_o.blue  = blue_p[uyvy_pkg::ProdW-1:uyvy_pkg::FracW];

endmodule

`default_nettype wire

// ===== sv/uyvy_pixel.sv =====
// ----------------------------------------------------------------------------
// uyvy_pixel
// Adds the chroma terms to one luma sample and clamps each channel to a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module uyvy_pixel (
  input  logic [uyvy_pkg::ByteW-1:0] luma_i,
  input  uyvy_pkg::chroma_terms_t    terms_i,
  output logic [uyvy_pkg::ByteW-1:0] red_o,
  output logic [uyvy_pkg::ByteW-1:0] green_o,
  output logic [uyvy_pkg::ByteW-1:0] blue_o
);

  logic signed [uyvy_pkg::SumW-1:0] luma_s;
  logic signed [uyvy_pkg::SumW-1:0] red_sum;
  logic signed [uyvy_pkg::SumW-1:0] green_sum;
  logic signed [uyvy_pkg::SumW-1:0] blue_sum;

  assign luma_s    = $signed({2'b00, luma_i});
  assign red_sum   = luma_s + uyvy_pkg::SumW'(terms_i.red);
  assign green_sum = luma_s - uyvy_pkg::SumW'(terms_i.green);
  assign blue_sum  = luma_s + uyvy_pkg::SumW'(terms_i.blue);

  assign red_o   = uyvy_pkg::sat_byte(red_sum);
  assign green_o = uyvy_pkg::sat_byte(green_sum);
  assign blue_o  = uyvy_pkg::sat_byte(blue_sum);

endmodule

`default_nettype wire

// ===== sim/tb_uyvy_to_rgb_converter_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uyvy_to_rgb_converter_core
// Self-checking bench for the UYVY macropixel to RGB888 pair converter.
// ----------------------------------------------------------------------------
// Requests go in over a valid/ready handshake. A bit-true colour model, or a
// pair typed into the table, predicts the pixel pair for every accepted request.
// The prediction is queued, and each accepted result is compared against the
// oldest prediction. A short table of hand-picked macropixels comes first:
// neutral chroma, both chroma extremes, luma rails, clamping on either side
// and bit patterns. Randomised traffic follows in three idling phases, with
// the receiver slow, then the sender slow, and finally both running flat out.
// ----------------------------------------------------------------------------

module tb_uyvy_to_rgb_converter_core;

  // Fixed-point colour coefficients, scale 1024
  localparam int CoefRv     = 1436;
  localparam int CoefGu     = 352;
  localparam int CoefGv     = 731;
  localparam int CoefBu     = 1814;
  localparam int FracBits   = 10;
  localparam int ChromaBias = 128;
  localparam int ByteTop    = 255;

  localparam int RandPerPhase = 245;
  localparam int StallLimit   = 2000;  // cycles with no handshake on either side
  localparam int DrainCycles  = 8;     // slack after the last result is taken

  typedef logic [uyvy_pkg::ByteW-1:0] byte_t;

  typedef struct packed {
    byte_t chroma_u;
    byte_t luma_first;
    byte_t chroma_v;
    byte_t luma_second;
    logic  frame_end;
  } macropixel_t;

  typedef struct packed {
    byte_t red_first;
    byte_t green_first;
    byte_t blue_first;
    byte_t red_second;
    byte_t green_second;
    byte_t blue_second;
    logic  frame_end;
  } rgb_pair_t;

  // One row of the directed table. Where fixed is set the expected pair is
  // typed in. Otherwise the colour model works it out.
  typedef struct packed {
    macropixel_t req;
    logic        fixed;
    rgb_pair_t   want;
  } stim_row_t;

  localparam int NumRows = 14;

  stim_row_t directed_rows [NumRows] = '{
    // neutral chroma, luma at both rails
    '{'{8'd128, 8'd0,   8'd128, 8'd255, 1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b0}},
    '{'{8'd128, 8'd128, 8'd128, 8'd128, 1'b1}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1}},
    '{'{8'd128, 8'd255, 8'd128, 8'd0,   1'b1}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1}},
    // most negative chroma: red and blue clamp low, green clamps high
    '{'{8'd0,   8'd0,   8'd0,   8'd255, 1'b0}, 1'b1,
      '{8'd0,   8'd136, 8'd0,   8'd75,  8'd255, 8'd28,  1'b0}},
    // most positive chroma: the reverse
    '{'{8'd255, 8'd255, 8'd255, 8'd0,   1'b1}, 1'b1,
      '{8'd255, 8'd121, 8'd255, 8'd178, 8'd0,   8'd224, 1'b1}},
    // mixed-sign chroma and values either side of the bias
    '{'{8'd0,   8'd128, 8'd255, 8'd128, 1'b0}, 1'b0, '0},
    '{'{8'd255, 8'd128, 8'd0,   8'd128, 1'b0}, 1'b0, '0},
    '{'{8'd127, 8'd64,  8'd129, 8'd192, 1'b0}, 1'b0, '0},
    '{'{8'd129, 8'd200, 8'd127, 8'd50,  1'b1}, 1'b0, '0},
    // alternating bit patterns
    '{'{8'h55,  8'hAA,  8'h55,  8'hAA,  1'b0}, 1'b0, '0},
    '{'{8'hAA,  8'h55,  8'hAA,  8'h55,  1'b1}, 1'b0, '0},
    '{'{8'd1,   8'd254, 8'd254, 8'd1,   1'b0}, 1'b0, '0},
    // video-range luma with strong chroma
    '{'{8'd200, 8'd16,  8'd60,  8'd235, 1'b0}, 1'b0, '0},
    '{'{8'd90,  8'd235, 8'd240, 8'd16,  1'b1}, 1'b0, '0}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_ready_o;
  byte_t chroma_u_i;
  byte_t luma_first_i;
  byte_t chroma_v_i;
  byte_t luma_second_i;
  logic  frame_end_in_i;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  byte_t red_first_o;
  byte_t green_first_o;
  byte_t blue_first_o;
  byte_t red_second_o;
  byte_t green_second_o;
  byte_t blue_second_o;
  logic  frame_end_out_o;

  rgb_pair_t rgb_pair_q[$];   // predicted pairs, oldest first
  int        errors        = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_cnt     = 0;

  uyvy_to_rgb_converter_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .chroma_u_i      (chroma_u_i),
    .luma_first_i    (luma_first_i),
    .chroma_v_i      (chroma_v_i),
    .luma_second_i   (luma_second_i),
    .frame_end_in_i  (frame_end_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_first_o     (red_first_o),
    .green_first_o   (green_first_o),
    .blue_first_o    (blue_first_o),
    .red_second_o    (red_second_o),
    .green_second_o  (green_second_o),
    .blue_second_o   (blue_second_o),
    .frame_end_out_o (frame_end_out_o)
  );

  // 50 MHz
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic byte_t clamp_channel(input int x);
    byte_t res;
    if (x < 0) begin
      res = '0;
    end else if (x > ByteTop) begin
      res = byte_t'(ByteTop);
    end else begin
      res = byte_t'(x);
    end
    return res;
  endfunction

  // Colour model. Both pixels share the chroma terms. The arithmetic shift
  // of a signed int gives the floor that the hardware uses.
  function automatic rgb_pair_t convert_macropixel(input macropixel_t mp);
    int        u;
    int        v;
    int        red_term;
    int        green_term;
    int        blue_term;
    rgb_pair_t res;
    u          = int'(mp.chroma_u) - ChromaBias;
    v          = int'(mp.chroma_v) - ChromaBias;
    red_term   = (v * CoefRv) >>> FracBits;
    green_term = (u * CoefGu + v * CoefGv) >>> FracBits;
    blue_term  = (u * CoefBu) >>> FracBits;
    res.red_first    = clamp_channel(int'(mp.luma_first) + red_term);
    res.green_first  = clamp_channel(int'(mp.luma_first) - green_term);
    res.blue_first   = clamp_channel(int'(mp.luma_first) + blue_term);
    res.red_second   = clamp_channel(int'(mp.luma_second) + red_term);
    res.green_second = clamp_channel(int'(mp.luma_second) - green_term);
    res.blue_second  = clamp_channel(int'(mp.luma_second) + blue_term);
    res.frame_end    = mp.frame_end;
    return res;
  endfunction

  // Rails get a fair share so that clamping is hit often
  function automatic byte_t pick_byte();
    byte_t res;
    case ($urandom_range(7))
      0:       res = '0;
      1:       res = '1;
      default: res = byte_t'($urandom_range(ByteTop));
    endcase
    return res;
  endfunction

  // Entered and left at a falling edge. valid is left high on exit so that
  // back-to-back requests carry no bubble unless the gap draw asks for one.
  task automatic send_macropixel(input macropixel_t mp, input rgb_pair_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    chroma_u_i     <= mp.chroma_u;
    luma_first_i   <= mp.luma_first;
    chroma_v_i     <= mp.chroma_v;
    luma_second_i  <= mp.luma_second;
    frame_end_in_i <= mp.frame_end;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    rgb_pair_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input byte_t want, input byte_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk_i) begin : check_results
    rgb_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rgb_pair_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = rgb_pair_q.pop_front();
        check_field("red_first",     want.red_first,     red_first_o);
        check_field("green_first",   want.green_first,   green_first_o);
        check_field("blue_first",    want.blue_first,    blue_first_o);
        check_field("red_second",    want.red_second,    red_second_o);
        check_field("green_second",  want.green_second,  green_second_o);
        check_field("blue_second",   want.blue_second,   blue_second_o);
        check_field("frame_end_out", byte_t'(want.frame_end), byte_t'(frame_end_out_o));
      end
    end
  end

  // Watchdog: no handshake on either side for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    macropixel_t mp;
    in_valid_i     = 1'b0;
    chroma_u_i     = '0;
    luma_first_i   = '0;
    chroma_v_i     = '0;
    luma_second_i  = '0;
    frame_end_in_i = 1'b0;
    rst_ni         = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table, with the receiver slow
    send_idle_pct = 17;
    recv_idle_pct = 75;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].fixed) begin
        send_macropixel(directed_rows[i].req, directed_rows[i].want);
      end else begin
        send_macropixel(directed_rows[i].req, convert_macropixel(directed_rows[i].req));
      end
    end

    // random traffic: receiver slow, then sender slow, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RandPerPhase) begin
        mp.chroma_u    = pick_byte();
        mp.luma_first  = pick_byte();
        mp.chroma_v    = pick_byte();
        mp.luma_second = pick_byte();
        mp.frame_end   = ($urandom_range(15) == 0);
        send_macropixel(mp, convert_macropixel(mp));
      end
    end
    in_valid_i <= 1'b0;

    wait (rgb_pair_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && rgb_pair_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
